[rtl/mm_pkg.sv]
// Shared types and constants for the matrix multiply block.
// Used by every module of the block but mm_ram; depends on nothing.
`timescale 1ns / 1ps

package mm_pkg;

  // Element format: signed Q16.16.
  localparam int DATA_W  = 32;
  localparam int FRAC_W  = 16;
  localparam int PROD_W  = 2 * DATA_W;

  // Dimension registers and product indices.
  localparam int DIM_W   = 4;
  localparam int IDX_W   = 3;
  localparam int REG_IDX_W = 2;

  localparam int MAX_DIM_DEF = 8;

  // Register indexes of the configuration port.
  localparam logic [REG_IDX_W-1:0] REG_A_ROWS = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_A_COLS = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_B_ROWS = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_B_COLS = 2'd3;

  // Tag that travels with each multiply through the arithmetic pipeline.
  typedef struct packed {
    logic             valid;
    logic             first;      // first term of a dot product
    logic             last_k;     // final term of a dot product
    logic             last_elem;  // final element of the product matrix
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
  } mm_tag_t;

  // Command from the sequencer to the arithmetic unit.
  typedef struct packed {
    logic    err;  // emit the dimension-error result
    mm_tag_t tag;
  } mm_cmd_t;

endpackage

[rtl/mm_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package dependency.
`timescale 1ns / 1ps

module mm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/mm_ctrl.sv]
// Load counter, dimension registers and product sequencer.
// Depends on mm_pkg for widths, register indexes and the command struct.
`timescale 1ns / 1ps

module mm_ctrl #(
  parameter int MAX_DIM = mm_pkg::MAX_DIM_DEF,
  localparam int DEPTH  = MAX_DIM * MAX_DIM,
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic                         cfg_we,
  input  logic [mm_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [mm_pkg::DIM_W-1:0]     cfg_wdata,
  output logic                         a_we,
  output logic                         b_we,
  output logic [AW-1:0]                waddr,
  output logic [AW-1:0]                a_raddr,
  output logic [AW-1:0]                b_raddr,
  output mm_pkg::mm_cmd_t              cmd,
  input  logic                         fin
);

  import mm_pkg::*;

  localparam int LCW = (2 * DEPTH > 1) ? $clog2(2 * DEPTH) : 1;
  localparam int NAW = $clog2(DEPTH + 1);
  localparam int TW  = LCW + 1;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_RUN   = 3'b010,
    S_DRAIN = 3'b100
  } state_t;

  state_t             state_r, state_nxt;
  logic [DIM_W-1:0]   a_rows_r, a_cols_r, b_rows_r, b_cols_r;
  logic [LCW-1:0]     lc_r, lc_nxt;
  logic [IDX_W-1:0]   i_r, i_nxt, j_r, j_nxt, l_r, l_nxt;
  logic [AW-1:0]      a_addr_r, a_addr_nxt, a_base_r, a_base_nxt, b_addr_r, b_addr_nxt;

  logic [DIM_W-1:0]   ar, ac, br, bc;
  logic [2*DIM_W-1:0] na_full, nb_full;
  logic [NAW-1:0]     na, nb;
  logic [TW-1:0]      total, lc_inc;
  logic [LCW-1:0]     lc_eff, b_off;
  logic               accept, is_a, final_beat, mismatch;
  logic               lk, lj, li;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
    logic [DIM_W-1:0] r;
    r = d;
    if (d == '0) begin
      r = DIM_W'(1);
    end else if (d > DIM_W'(MAX_DIM)) begin
      r = DIM_W'(MAX_DIM);
    end
    return r;
  endfunction

  // Effective dimensions and matrix sizes.
  assign ar       = clamp_dim(a_rows_r);
  assign ac       = clamp_dim(a_cols_r);
  assign br       = clamp_dim(b_rows_r);
  assign bc       = clamp_dim(b_cols_r);
  assign na_full  = {{DIM_W{1'b0}}, ar} * {{DIM_W{1'b0}}, ac};
  assign nb_full  = {{DIM_W{1'b0}}, br} * {{DIM_W{1'b0}}, bc};
  assign na       = na_full[NAW-1:0];
  assign nb       = nb_full[NAW-1:0];
  assign total    = TW'(na) + TW'(nb);
  assign mismatch = (ac != br);

  // Load path: each accepted beat goes to the left or right store.
  assign busy       = (state_r != S_IDLE);
  assign accept     = start && !busy;
  assign lc_eff     = (TW'(lc_r) >= total) ? '0 : lc_r;
  assign is_a       = TW'(lc_eff) < TW'(na);
  assign b_off      = lc_eff - LCW'(na);
  assign lc_inc     = TW'(lc_eff) + TW'(1);
  assign final_beat = (lc_inc == total);
  assign a_we       = accept && is_a;
  assign b_we       = accept && !is_a;
  assign waddr      = is_a ? lc_eff[AW-1:0] : b_off[AW-1:0];

  always_comb begin
    lc_nxt = lc_r;
    if (cfg_we) begin
      lc_nxt = '0;
    end else if (accept) begin
      lc_nxt = final_beat ? '0 : lc_inc[LCW-1:0];
    end
  end

  // Dimension registers; any write restarts the load.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_rows_r <= DIM_W'(1);
      a_cols_r <= DIM_W'(1);
      b_rows_r <= DIM_W'(1);
      b_cols_r <= DIM_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_A_ROWS: a_rows_r <= cfg_wdata;
        REG_A_COLS: a_cols_r <= cfg_wdata;
        REG_B_ROWS: b_rows_r <= cfg_wdata;
        REG_B_COLS: b_cols_r <= cfg_wdata;
        default:    a_rows_r <= a_rows_r;
      endcase
    end
  end

  // Loop ends of the product walk: inner term, column and row.
  assign lk = ({1'b0, l_r} == ac - DIM_W'(1));
  assign lj = ({1'b0, j_r} == bc - DIM_W'(1));
  assign li = ({1'b0, i_r} == ar - DIM_W'(1));

  // Sequencer: one multiply issued per cycle while running.
  always_comb begin
    state_nxt  = state_r;
    i_nxt      = i_r;
    j_nxt      = j_r;
    l_nxt      = l_r;
    a_addr_nxt = a_addr_r;
    a_base_nxt = a_base_r;
    b_addr_nxt = b_addr_r;
    case (state_r)
      S_IDLE: begin
        if (accept && final_beat && !mismatch) begin
          state_nxt  = S_RUN;
          i_nxt      = '0;
          j_nxt      = '0;
          l_nxt      = '0;
          a_addr_nxt = '0;
          a_base_nxt = '0;
          b_addr_nxt = '0;
        end
      end
      S_RUN: begin
        if (!lk) begin
          l_nxt      = l_r + IDX_W'(1);
          a_addr_nxt = a_addr_r + AW'(1);
          b_addr_nxt = b_addr_r + AW'(bc);
        end else begin
          l_nxt = '0;
          if (!lj) begin
            j_nxt      = j_r + IDX_W'(1);
            a_addr_nxt = a_base_r;
            b_addr_nxt = AW'(j_r) + AW'(1);
          end else begin
            j_nxt      = '0;
            b_addr_nxt = '0;
            if (!li) begin
              i_nxt      = i_r + IDX_W'(1);
              a_base_nxt = a_base_r + AW'(ac);
              a_addr_nxt = a_base_r + AW'(ac);
            end else begin
              state_nxt = S_DRAIN;
            end
          end
        end
      end
      S_DRAIN: begin
        if (fin) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      lc_r    <= '0;
    end else begin
      state_r <= state_nxt;
      lc_r    <= lc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r      <= i_nxt;
    j_r      <= j_nxt;
    l_r      <= l_nxt;
    a_addr_r <= a_addr_nxt;
    a_base_r <= a_base_nxt;
    b_addr_r <= b_addr_nxt;
  end

  // Read addresses and the command for the arithmetic unit.
  assign a_raddr           = a_addr_r;
  assign b_raddr           = b_addr_r;
  assign cmd.err           = accept && final_beat && mismatch;
  assign cmd.tag.valid     = (state_r == S_RUN);
  assign cmd.tag.first     = (l_r == '0);
  assign cmd.tag.last_k    = lk;
  assign cmd.tag.last_elem = lj && li;
  assign cmd.tag.row       = i_r;
  assign cmd.tag.col       = j_r;

endmodule

[rtl/mm_mac.sv]
// Shared multiply-accumulate unit with rounding, saturation and result register.
// Depends on mm_pkg for the element format and the command struct.
`timescale 1ns / 1ps

module mm_mac #(
  parameter int MAX_DIM = mm_pkg::MAX_DIM_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  mm_pkg::mm_cmd_t              cmd,
  input  logic [mm_pkg::DATA_W-1:0]    a_data,
  input  logic [mm_pkg::DATA_W-1:0]    b_data,
  output logic                         out_strobe,
  output logic signed [mm_pkg::DATA_W-1:0] out_product_value,
  output logic [mm_pkg::IDX_W-1:0]     out_row,
  output logic [mm_pkg::IDX_W-1:0]     out_col,
  output logic                         out_saturated,
  output logic                         out_dim_error,
  output logic                         out_last,
  output logic                         fin
);

  import mm_pkg::*;

  localparam int ACC_W = PROD_W + $clog2(MAX_DIM) + 1;
  localparam int RW    = ACC_W - FRAC_W;
  localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) << (FRAC_W - 1);
  localparam logic signed [DATA_W-1:0] VMAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] VMIN = {1'b1, {(DATA_W-1){1'b0}}};

  mm_tag_t                   t1_r, t2_r, t3_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [ACC_W-1:0]   acc_r, acc_base, acc_nxt, rnd_sum;
  logic [RW-1:0]             rnd_q;
  logic                      over, under;

  // Tag pipeline: aligned with read data, product and running sum.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t1_r <= '0;
      t2_r <= '0;
      t3_r <= '0;
    end else begin
      t1_r <= cmd.tag;
      t2_r <= t1_r;
      t3_r <= t2_r;
    end
  end

  // One 32x32 signed multiply per cycle.
  always_ff @(posedge clk) begin
    prod_r <= $signed(a_data) * $signed(b_data);
  end

  // Exact Q32.32 accumulation; a new dot product restarts from zero.
  assign acc_base = t2_r.first ? '0 : acc_r;
  assign acc_nxt  = acc_base + ACC_W'(prod_r);

  always_ff @(posedge clk) begin
    if (t2_r.valid) begin
      acc_r <= acc_nxt;
    end
  end

  // Round to nearest with ties upward, then clip to 32 bits.
  assign rnd_sum = acc_r + HALF;
  assign rnd_q   = rnd_sum[ACC_W-1:FRAC_W];
  assign over    = !rnd_q[RW-1] && (|rnd_q[RW-2:DATA_W-1]);
  assign under   = rnd_q[RW-1] && !(&rnd_q[RW-2:DATA_W-1]);
  assign fin     = t3_r.valid && t3_r.last_k && t3_r.last_elem;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe <= 1'b0;
    end else begin
      out_strobe <= cmd.err || (t3_r.valid && t3_r.last_k);
    end
  end

  // Result beat: either the dimension error or one product element.
  always_ff @(posedge clk) begin
    if (cmd.err) begin
      out_product_value <= '0;
      out_row           <= '0;
      out_col           <= '0;
      out_saturated     <= 1'b0;
      out_dim_error     <= 1'b1;
      out_last          <= 1'b1;
    end else if (t3_r.valid && t3_r.last_k) begin
      out_product_value <= over ? VMAX : (under ? VMIN : $signed(rnd_q[DATA_W-1:0]));
      out_row           <= t3_r.row;
      out_col           <= t3_r.col;
      out_saturated     <= over || under;
      out_dim_error     <= 1'b0;
      out_last          <= t3_r.last_elem;
    end
  end

endmodule

[rtl/matrix_multiply.sv]
// Matrix multiply top level: element stores, sequencer and arithmetic unit.
// Depends on mm_pkg, mm_ram, mm_ctrl and mm_mac.
//
// Elements of A and then of B are taken one per cycle while busy is low, each
// on a beat with start high. The beat that delivers the last element of B
// starts the product: one shared 32x32 multiplier and a wide accumulator run
// one term per cycle through the address, store read, product, running-sum
// and result registers, and busy stays high until the final result.
// Results appear for one cycle each, marked by out_strobe; the receiver
// cannot stall them and must take every beat. A dimension mismatch gives a
// single error beat on the cycle after the last load, with no busy period.
// The stores need no clearing after reset.
`timescale 1ns / 1ps

module matrix_multiply #(
  parameter int MAX_DIM = mm_pkg::MAX_DIM_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic signed [mm_pkg::DATA_W-1:0] in_element_value,
  output logic                             out_strobe,
  output logic signed [mm_pkg::DATA_W-1:0] out_product_value,
  output logic [mm_pkg::IDX_W-1:0]         out_row,
  output logic [mm_pkg::IDX_W-1:0]         out_col,
  output logic                             out_saturated,
  output logic                             out_dim_error,
  output logic                             out_last,
  input  logic                             cfg_we,
  input  logic [mm_pkg::REG_IDX_W-1:0]     cfg_index,
  input  logic [mm_pkg::DIM_W-1:0]         cfg_wdata
);

  import mm_pkg::*;

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic              a_we, b_we, fin;
  logic [AW-1:0]     waddr, a_raddr, b_raddr;
  logic [DATA_W-1:0] a_data, b_data;
  mm_cmd_t           cmd;

  // Sequencer and load control.
  mm_ctrl #(.MAX_DIM(MAX_DIM)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .a_we      (a_we),
    .b_we      (b_we),
    .waddr     (waddr),
    .a_raddr   (a_raddr),
    .b_raddr   (b_raddr),
    .cmd       (cmd),
    .fin       (fin)
  );

  // Left matrix store.
  mm_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_left (
    .clk   (clk),
    .we    (a_we),
    .waddr (waddr),
    .wdata (in_element_value),
    .raddr (a_raddr),
    .rdata (a_data)
  );

  // Right matrix store.
  mm_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_right (
    .clk   (clk),
    .we    (b_we),
    .waddr (waddr),
    .wdata (in_element_value),
    .raddr (b_raddr),
    .rdata (b_data)
  );

  // Shared multiply-accumulate unit and result register.
  mm_mac #(.MAX_DIM(MAX_DIM)) u_mac (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .a_data            (a_data),
    .b_data            (b_data),
    .out_strobe        (out_strobe),
    .out_product_value (out_product_value),
    .out_row           (out_row),
    .out_col           (out_col),
    .out_saturated     (out_saturated),
    .out_dim_error     (out_dim_error),
    .out_last          (out_last),
    .fin               (fin)
  );

endmodule

[rtl/mm_checker.sv]
// Port-level checks for the matrix multiply block, bound to the top level.
// Depends on mm_pkg for port widths.
`timescale 1ns / 1ps

module mm_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             start,
  input logic                             busy,
  input logic                             out_strobe,
  input logic signed [mm_pkg::DATA_W-1:0] out_product_value,
  input logic [mm_pkg::IDX_W-1:0]         out_row,
  input logic [mm_pkg::IDX_W-1:0]         out_col,
  input logic                             out_saturated,
  input logic                             out_dim_error,
  input logic                             out_last
);

  import mm_pkg::*;

  // A product run only starts on an accepted load beat.
  a_busy_start: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start))
    else $error("busy rose without a load beat");

  // The error beat carries a fixed payload and ends the run.
  a_err_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_dim_error) |->
      (out_last && !out_saturated && out_product_value == '0 &&
       out_row == '0 && out_col == '0))
    else $error("malformed dimension-error beat");

  // A clipped element sits at one of the two range limits.
  a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_saturated) |->
      (out_product_value == {1'b0, {(DATA_W-1){1'b1}}} ||
       out_product_value == {1'b1, {(DATA_W-1){1'b0}}}))
    else $error("saturated beat not at a range limit");

  // busy drops exactly as the final product beat appears.
  a_busy_end: assert property (@(posedge clk) disable iff (!rst_n)
    ($fell(busy) && $past(rst_n)) |-> (out_strobe && out_last))
    else $error("busy fell without the final beat");

  // The final beat of a run leaves the block ready.
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_last) |-> !busy)
    else $error("still busy on the final beat");

endmodule

bind matrix_multiply mm_checker u_mm_checker (.*);

[tb/sv/tb_matrix_multiply.sv]
// Self-checking testbench for the matrix multiply block: streams A and B
// elements, predicts every product beat and checks each one as it appears.
// Depends on mm_pkg and on the matrix_multiply RTL only.
`timescale 1ns / 1ps

module tb_matrix_multiply;
  import mm_pkg::*;

  localparam int ITEM_TARGET    = 430;
  localparam int SETTLE_CYCLES  = 8;
  localparam int TAIL_CYCLES    = 16;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int PRINT_LIMIT    = 30;

  // One product beat as seen on the result ports.
  typedef struct {
    logic signed [DATA_W-1:0] value;
    logic [IDX_W-1:0]         row;
    logic [IDX_W-1:0]         col;
    logic                     sat;
    logic                     err;
    logic                     last;
  } prod_beat_t;

  // Scoreboard: keeps its own copy of the stores and dimension registers,
  // computes the product when the last element of B is noted, and checks
  // each result beat against the oldest expected one.
  class mm_scoreboard;
    logic signed [DATA_W-1:0] left_elems [MAX_DIM_DEF*MAX_DIM_DEF];
    logic signed [DATA_W-1:0] right_elems [MAX_DIM_DEF*MAX_DIM_DEF];
    logic [DIM_W-1:0]         dim_reg [4];
    int unsigned              load_count;
    int unsigned              fail_count;
    prod_beat_t               expected_beats [$];

    function new();
      for (int r = 0; r < 4; r++) dim_reg[r] = 4'd1;
      load_count = 0;
      fail_count = 0;
    endfunction

    // Zero is taken as one and anything above the maximum as the maximum.
    function int unsigned eff_dim(logic [DIM_W-1:0] d);
      if (d == 0) return 1;
      if (d > MAX_DIM_DEF) return MAX_DIM_DEF;
      return 32'(d);
    endfunction

    // Any register write also abandons a partly loaded pair of matrices.
    function void write_dim(logic [REG_IDX_W-1:0] idx, logic [DIM_W-1:0] val);
      dim_reg[idx] = val;
      load_count = 0;
    endfunction

    function int unsigned elements_per_run();
      return eff_dim(dim_reg[REG_A_ROWS]) * eff_dim(dim_reg[REG_A_COLS]) +
             eff_dim(dim_reg[REG_B_ROWS]) * eff_dim(dim_reg[REG_B_COLS]);
    endfunction

    function void note_element(logic signed [DATA_W-1:0] v);
      int unsigned        ar, ac, br, bc, na, nb;
      logic signed [79:0] acc;
      logic signed [79:0] rnd;
      longint             x;
      longint             y;
      prod_beat_t         beat;
      ar = eff_dim(dim_reg[REG_A_ROWS]);
      ac = eff_dim(dim_reg[REG_A_COLS]);
      br = eff_dim(dim_reg[REG_B_ROWS]);
      bc = eff_dim(dim_reg[REG_B_COLS]);
      na = ar * ac;
      nb = br * bc;
      if (load_count >= na + nb) load_count = 0;
      if (load_count < na) left_elems[load_count] = v;
      else right_elems[load_count - na] = v;
      load_count++;
      if (load_count < na + nb) return;
      load_count = 0;

      // Inner dimensions disagree: a single error beat and no product.
      if (ac != br) begin
        beat.value = '0;
        beat.row   = '0;
        beat.col   = '0;
        beat.sat   = 1'b0;
        beat.err   = 1'b1;
        beat.last  = 1'b1;
        expected_beats.push_back(beat);
        return;
      end

      // Exact sum of Q32.32 terms, rounded half up to Q16.16, then clipped.
      for (int i = 0; i < ar; i++) begin
        for (int j = 0; j < bc; j++) begin
          acc = '0;
          for (int k = 0; k < ac; k++) begin
            x = longint'(left_elems[i * ac + k]);
            y = longint'(right_elems[k * bc + j]);
            acc += 80'(x * y);
          end
          rnd = (acc + 80'sd32768) >>> FRAC_W;
          beat.sat = 1'b0;
          if (rnd > 80'sd2147483647) begin
            rnd = 80'sd2147483647;
            beat.sat = 1'b1;
          end
          if (rnd < -80'sd2147483648) begin
            rnd = -80'sd2147483648;
            beat.sat = 1'b1;
          end
          beat.value = rnd[DATA_W-1:0];
          beat.row   = i[IDX_W-1:0];
          beat.col   = j[IDX_W-1:0];
          beat.err   = 1'b0;
          beat.last  = (i == ar - 1 && j == bc - 1);
          expected_beats.push_back(beat);
        end
      end
    endfunction

    task report(string msg);
      fail_count++;
      if (fail_count <= PRINT_LIMIT) $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    task check_result(prod_beat_t got);
      prod_beat_t want;
      if (expected_beats.size() == 0) begin
        report($sformatf("unexpected beat row %0d col %0d value %h",
                         got.row, got.col, got.value));
        return;
      end
      want = expected_beats.pop_front();
      if (got.value !== want.value)
        report($sformatf("value %h, expected %h (row %0d col %0d)",
                         got.value, want.value, want.row, want.col));
      if (got.row !== want.row)
        report($sformatf("row %0d, expected %0d", got.row, want.row));
      if (got.col !== want.col)
        report($sformatf("col %0d, expected %0d", got.col, want.col));
      if (got.sat !== want.sat)
        report($sformatf("saturated %b, expected %b (row %0d col %0d)",
                         got.sat, want.sat, want.row, want.col));
      if (got.err !== want.err)
        report($sformatf("dim_error %b, expected %b", got.err, want.err));
      if (got.last !== want.last)
        report($sformatf("last %b, expected %b (row %0d col %0d)",
                         got.last, want.last, want.row, want.col));
    endtask

    function int pending();
      return expected_beats.size();
    endfunction
  endclass

  logic                     clk;
  logic                     rst_n = 1'b0;
  logic                     start = 1'b0;
  logic                     busy;
  logic signed [DATA_W-1:0] in_element_value = '0;
  logic                     out_strobe;
  logic signed [DATA_W-1:0] out_product_value;
  logic [IDX_W-1:0]         out_row;
  logic [IDX_W-1:0]         out_col;
  logic                     out_saturated;
  logic                     out_dim_error;
  logic                     out_last;
  logic                     cfg_we = 1'b0;
  logic [REG_IDX_W-1:0]     cfg_index = REG_A_ROWS;
  logic [DIM_W-1:0]         cfg_wdata = '0;

  mm_scoreboard sb = new();
  prod_beat_t   seen_beat;
  int           items_sent;

  matrix_multiply dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_element_value (in_element_value),
    .out_strobe       (out_strobe),
    .out_product_value(out_product_value),
    .out_row          (out_row),
    .out_col          (out_col),
    .out_saturated    (out_saturated),
    .out_dim_error    (out_dim_error),
    .out_last         (out_last),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Every strobed beat goes straight to the scoreboard.
  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      seen_beat.value = out_product_value;
      seen_beat.row   = out_row;
      seen_beat.col   = out_col;
      seen_beat.sat   = out_saturated;
      seen_beat.err   = out_dim_error;
      seen_beat.last  = out_last;
      sb.check_result(seen_beat);
    end
  end

  // Watchdog: ends the run when neither side has moved a beat for too long.
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((start && !busy) || out_strobe || cfg_we) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  // Mostly back-to-back, sometimes a short pause, now and then a long one.
  function int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Mix of small values that stay in range, full-range values and corners.
  function logic signed [DATA_W-1:0] rand_element();
    int pick;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $signed($urandom_range(0, 524288)) - 262144;
      4, 5:       return $signed($urandom_range(0, 131072)) - 65536;
      6, 7:       return $urandom;
      8:          return $signed($urandom_range(0, 33554432)) - 16777216;
      default: begin
        pick = $urandom_range(0, 7);
        case (pick)
          0:       return 32'sh7FFF_FFFF;
          1:       return 32'sh8000_0000;
          2:       return 32'sh0000_0000;
          3:       return 32'sh0000_0001;
          4:       return -32'sh0000_0001;
          5:       return 32'sh0001_0000;
          6:       return -32'sh0001_0000;
          default: return 32'sh0000_8000;
        endcase
      end
    endcase
  endfunction

  function int rand_dim();
    if ($urandom_range(0, 9) < 7) return $urandom_range(1, 4);
    return $urandom_range(1, MAX_DIM_DEF);
  endfunction

  // Register value for a dimension, sometimes in the out-of-range encodings.
  function logic [DIM_W-1:0] encode_dim(int d);
    if (d == 1 && $urandom_range(0, 4) == 0) return 4'd0;
    if (d == MAX_DIM_DEF && $urandom_range(0, 1) == 1)
      return DIM_W'($urandom_range(9, 15));
    return DIM_W'(d);
  endfunction

  // Offers one element and returns at the edge that accepts it.
  task load_element(logic signed [DATA_W-1:0] v, int gap);
    start <= 1'b1;
    in_element_value <= v;
    do @(posedge clk); while (busy);
    sb.note_element(v);
    items_sent++;
    if (gap > 0) begin
      start <= 1'b0;
      in_element_value <= $urandom;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stops loading, waits for every expected beat and lets the block settle.
  task drain_products();
    start <= 1'b0;
    in_element_value <= $urandom;
    while (sb.pending() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Leaves the write enable high so that several writes run back to back.
  task write_dim_reg(logic [REG_IDX_W-1:0] idx, logic [DIM_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.write_dim(idx, val);
  endtask

  task set_dims(logic [DIM_W-1:0] ar, logic [DIM_W-1:0] ac,
                logic [DIM_W-1:0] br, logic [DIM_W-1:0] bc);
    write_dim_reg(REG_A_ROWS, ar);
    write_dim_reg(REG_A_COLS, ac);
    write_dim_reg(REG_B_ROWS, br);
    write_dim_reg(REG_B_COLS, bc);
    cfg_we <= 1'b0;
  endtask

  // One run with random data; a few are cut short to exercise the abort.
  task run_matrices(bit allow_abort);
    int total;
    int count;
    bit steady;
    total  = sb.elements_per_run();
    count  = total;
    steady = ($urandom_range(0, 3) == 0);
    if (allow_abort && total > 1 && $urandom_range(0, 9) == 0)
      count = $urandom_range(1, total - 1);
    for (int k = 0; k < count; k++) load_element(rand_element(), steady ? 0 : rand_gap());
    drain_products();
  endtask

  initial begin : stimulus
    int phase;
    int ar, ac, br, bc;
    items_sent = 0;
    phase = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Reset dimensions are 1x1 by 1x1: saturation both ways and rounding ties.
    load_element(32'sh7FFF_FFFF, 0);
    load_element(32'sh7FFF_FFFF, 0);
    load_element(32'sh8000_0000, 0);
    load_element(32'sh8000_0000, 1);
    load_element(32'sh8000_0000, 0);
    load_element(32'sh7FFF_FFFF, 0);
    load_element(32'sh0000_0001, 2);
    load_element(32'sh0000_8000, 0);
    load_element(-32'sh0000_0001, 0);
    load_element(32'sh0000_8000, 0);
    drain_products();

    // Registers written as zero act as one.
    set_dims(4'd0, 4'd0, 4'd0, 4'd0);
    load_element(32'sh0003_0000, 0);
    load_element(-32'sh0000_8000, 0);
    drain_products();

    // Inner dimensions that disagree give the error beat only.
    set_dims(4'd1, 4'd2, 4'd1, 4'd1);
    load_element(32'sh0001_0000, 0);
    load_element(32'sh0002_0000, 0);
    load_element(32'sh0004_0000, 0);
    drain_products();

    // A partial load abandoned by a register write, then a fresh 1x2 by 2x1.
    load_element(32'sh1234_5678, 0);
    drain_products();
    write_dim_reg(REG_B_ROWS, 4'd2);
    cfg_we <= 1'b0;
    load_element(32'sh0001_8000, 0);
    load_element(-32'sh0002_0000, 1);
    load_element(32'sh0000_4000, 0);
    load_element(32'sh0003_0000, 0);
    drain_products();

    // Random runs: a few fixed corner shapes first, then random shapes.
    while (items_sent < ITEM_TARGET) begin
      case (phase)
        0:       set_dims(4'd15, 4'd8, 4'd9, 4'd15);
        1:       set_dims(4'd1, 4'd8, 4'd8, 4'd1);
        2:       set_dims(4'd8, 4'd1, 4'd1, 4'd8);
        default: begin
          ar = rand_dim();
          ac = rand_dim();
          bc = rand_dim();
          br = ac;
          if ($urandom_range(0, 4) == 0) begin
            br = rand_dim();
            if (br == ac) br = (ac % MAX_DIM_DEF) + 1;
          end
          set_dims(encode_dim(ar), encode_dim(ac), encode_dim(br), encode_dim(bc));
        end
      endcase
      run_matrices(phase > 2);
      phase++;
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.pending() > 0)
      sb.report($sformatf("%0d expected beats never appeared", sb.pending()));
    if (sb.fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
